>>> src/assert_macros.svh
// assertion helpers for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define LCT_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// consequent checked in the cycle after the trigger
`define LCT_ASSERT_NEXT(name, clk, rst_n, trig, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
    else $error(msg);

`endif

>>> src/lct_pkg.sv
package lct_pkg;

  // data path widths and the default capacity
  localparam int DATA_W       = 32;
  localparam int CAP_REG_W    = 5;
  localparam int CAPACITY_DEF = 16;

  localparam logic [CAP_REG_W-1:0] CAP_RESET = 5'd16;

  // request kinds
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // one stored entry apart from its age rank
  typedef struct packed {
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] count;
  } entry_t;

  // request sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_AGE,
    ST_WRITE
  } state_t;

endpackage

>>> src/lct_ram.sv
module lct_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> src/lfu_cache_table.sv
// lfu key-value table: one request in flight, one result word per request
// steps: accept, scan of every slot, decide, an age pass over every slot when an entry is
//   written (skipped for a get miss or a zero capacity), then write and result word
// a new request is taken only after the last result word has been registered; a stalled
//   result word holds the write state
// reset: valid bits cleared, capacity 16; entry memories are not cleared
module lfu_cache_table #(
  parameter int CAPACITY = lct_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_op,
  input  logic signed [lct_pkg::DATA_W-1:0]   in_key,
  input  logic signed [lct_pkg::DATA_W-1:0]   in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_hit,
  output logic signed [lct_pkg::DATA_W-1:0]   out_read_value,
  output logic                                out_evicted,
  output logic signed [lct_pkg::DATA_W-1:0]   out_evicted_key,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lct_pkg::CAP_REG_W-1:0]       cfg_capacity_in_use
);

  localparam int DW     = lct_pkg::DATA_W;
  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (CNT_W > lct_pkg::CAP_REG_W) ? CNT_W : lct_pkg::CAP_REG_W;
  localparam int ENT_W  = $bits(lct_pkg::entry_t);
  localparam logic [CNT_W-1:0] LAST     = CNT_W'(CAPACITY);
  localparam logic [CMP_W-1:0] CAP_FULL = CMP_W'(CAPACITY);
  localparam logic [DW-1:0]    CNT_MAX  = '1;

  lct_pkg::state_t state_r, state_nxt;

  logic [lct_pkg::CAP_REG_W-1:0] cap_r;
  logic [CNT_W-1:0]              cnt_r;
  logic                          valid_r [CAPACITY];

  // request word
  logic          op_r;
  logic [DW-1:0] key_r;
  logic [DW-1:0] value_r;

  // scan results
  logic [CNT_W-1:0] fill_r;
  logic             found_r;
  logic [IDX_W-1:0] fidx_r;
  logic [DW-1:0]    fval_r;
  logic [DW-1:0]    fcnt_r;
  logic [IDX_W-1:0] frank_r;
  logic             mhave_r;
  logic [IDX_W-1:0] midx_r;
  logic [DW-1:0]    mkey_r;
  logic [DW-1:0]    mcnt_r;
  logic [IDX_W-1:0] mrank_r;
  logic             freehave_r;
  logic [IDX_W-1:0] freeidx_r;

  // update plan
  logic             upd_r;
  logic             all_r;
  logic [IDX_W-1:0] slot_r;
  logic [IDX_W-1:0] rlim_r;
  logic [DW-1:0]    wval_r;
  logic [DW-1:0]    wcnt_r;
  logic             res_hit_r;
  logic [DW-1:0]    res_rd_r;
  logic             res_ev_r;
  logic [DW-1:0]    res_evk_r;

  // output register
  logic          out_valid_r;
  logic          out_hit_r;
  logic [DW-1:0] out_rd_r;
  logic          out_ev_r;
  logic [DW-1:0] out_evk_r;

  // memory ports
  lct_pkg::entry_t  ent_rdata, ent_wdata;
  logic [ENT_W-1:0] ent_rbits;
  logic             ent_we;
  logic [IDX_W-1:0] rank_rdata, rank_wdata, rank_waddr;
  logic             rank_we;
  logic [IDX_W-1:0] raddr;

  logic             accept;
  logic             out_free;
  logic [IDX_W-1:0] p_idx;
  logic             p_valid;
  logic             proc;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign raddr    = cnt_r[IDX_W-1:0];
  assign p_idx    = IDX_W'(cnt_r - CNT_W'(1));
  assign p_valid  = valid_r[p_idx];
  assign proc     = (cnt_r != '0);
  assign ent_rdata = lct_pkg::entry_t'(ent_rbits);

  lct_ram #(
    .WIDTH (ENT_W),
    .DEPTH (CAPACITY)
  ) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (slot_r),
    .wdata (ent_wdata),
    .raddr (raddr),
    .rdata (ent_rbits)
  );

  lct_ram #(
    .WIDTH (IDX_W),
    .DEPTH (CAPACITY)
  ) u_rank_ram (
    .clk   (clk),
    .we    (rank_we),
    .waddr (rank_waddr),
    .wdata (rank_wdata),
    .raddr (raddr),
    .rdata (rank_rdata)
  );

  // decision from the scan results
  logic             dec_zero, dec_full, dec_upd, dec_all, dec_ev;
  logic [IDX_W-1:0] dec_slot, dec_rlim;
  logic [CMP_W-1:0] cap_live;

  always_comb begin
    cap_live = (CMP_W'(cap_r) > CAP_FULL) ? CAP_FULL : CMP_W'(cap_r);
    dec_zero = (cap_r == '0);
    dec_full = (CMP_W'(fill_r) >= cap_live);
    dec_upd  = 1'b0;
    dec_all  = 1'b0;
    dec_ev   = 1'b0;
    dec_slot = fidx_r;
    dec_rlim = frank_r;
    if (!dec_zero) begin
      if (found_r) begin
        dec_upd = 1'b1;
      end else if (op_r == lct_pkg::OP_PUT) begin
        if (dec_full) begin
          dec_upd  = mhave_r;
          dec_ev   = mhave_r;
          dec_slot = midx_r;
          dec_rlim = mrank_r;
        end else begin
          dec_upd  = freehave_r;
          dec_all  = 1'b1;
          dec_slot = freeidx_r;
        end
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lct_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = lct_pkg::ST_SCAN;
      end
      lct_pkg::ST_SCAN: begin
        if (cnt_r == LAST) state_nxt = lct_pkg::ST_DECIDE;
      end
      lct_pkg::ST_DECIDE: begin
        state_nxt = dec_upd ? lct_pkg::ST_AGE : lct_pkg::ST_WRITE;
      end
      lct_pkg::ST_AGE: begin
        if (cnt_r == LAST) state_nxt = lct_pkg::ST_WRITE;
      end
      lct_pkg::ST_WRITE: begin
        if (out_free) state_nxt = lct_pkg::ST_IDLE;
      end
      default: state_nxt = lct_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: handshake and memory writes
  always_comb begin
    in_ready   = 1'b0;
    ent_we     = 1'b0;
    rank_we    = 1'b0;
    rank_waddr = p_idx;
    rank_wdata = rank_rdata + IDX_W'(1);
    ent_wdata.key   = key_r;
    ent_wdata.value = wval_r;
    ent_wdata.count = wcnt_r;
    unique case (state_r)
      lct_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      lct_pkg::ST_AGE: begin
        // entries newer than the touched one grow one step older, all of them for a free-slot put
        rank_we = proc && p_valid && (p_idx != slot_r) &&
                  (all_r || (rank_rdata < rlim_r));
      end
      lct_pkg::ST_WRITE: begin
        ent_we     = upd_r && out_free;
        rank_we    = upd_r && out_free;
        rank_waddr = slot_r;
        rank_wdata = '0;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lct_pkg::ST_IDLE;
      cap_r       <= lct_pkg::CAP_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CAPACITY; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        cap_r <= cfg_capacity_in_use;
      end
      if (state_r == lct_pkg::ST_SCAN || state_r == lct_pkg::ST_AGE) begin
        cnt_r <= (cnt_r == LAST) ? '0 : cnt_r + CNT_W'(1);
      end else begin
        cnt_r <= '0;
      end
      if (state_r == lct_pkg::ST_WRITE && out_free) begin
        out_valid_r <= 1'b1;
        if (upd_r) valid_r[slot_r] <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request capture and scan accumulators
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r       <= in_op;
      key_r      <= in_key;
      value_r    <= in_value;
      fill_r     <= '0;
      found_r    <= 1'b0;
      mhave_r    <= 1'b0;
      freehave_r <= 1'b0;
    end else if (state_r == lct_pkg::ST_SCAN && proc) begin
      if (p_valid) begin
        fill_r <= fill_r + CNT_W'(1);
        if (!found_r && ent_rdata.key == key_r) begin
          found_r <= 1'b1;
          fidx_r  <= p_idx;
          fval_r  <= ent_rdata.value;
          fcnt_r  <= ent_rdata.count;
          frank_r <= rank_rdata;
        end
        // eviction candidate: fewest uses, oldest among equals
        if (!mhave_r || ent_rdata.count < mcnt_r ||
            (ent_rdata.count == mcnt_r && rank_rdata > mrank_r)) begin
          mhave_r <= 1'b1;
          midx_r  <= p_idx;
          mkey_r  <= ent_rdata.key;
          mcnt_r  <= ent_rdata.count;
          mrank_r <= rank_rdata;
        end
      end else if (!freehave_r) begin
        freehave_r <= 1'b1;
        freeidx_r  <= p_idx;
      end
    end
  end

  // update plan and result word
  always_ff @(posedge clk) begin
    if (state_r == lct_pkg::ST_DECIDE) begin
      upd_r     <= dec_upd;
      all_r     <= dec_all;
      slot_r    <= dec_slot;
      rlim_r    <= dec_rlim;
      res_hit_r <= !dec_zero && found_r;
      res_ev_r  <= dec_ev;
      res_evk_r <= dec_ev ? mkey_r : '0;
      res_rd_r  <= (!dec_zero && found_r && op_r == lct_pkg::OP_GET) ? fval_r : '0;
      if (found_r) begin
        wval_r <= (op_r == lct_pkg::OP_PUT) ? value_r : fval_r;
        wcnt_r <= (fcnt_r == CNT_MAX) ? fcnt_r : fcnt_r + DW'(1);
      end else begin
        wval_r <= value_r;
        wcnt_r <= DW'(1);
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (state_r == lct_pkg::ST_WRITE && out_free) begin
      out_hit_r <= res_hit_r;
      out_rd_r  <= res_rd_r;
      out_ev_r  <= res_ev_r;
      out_evk_r <= res_evk_r;
    end
  end

  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_read_value  = out_rd_r;
  assign out_evicted     = out_ev_r;
  assign out_evicted_key = out_evk_r;

endmodule

>>> src/lct_checker.sv
`include "assert_macros.svh"

module lct_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              out_hit,
  input logic [lct_pkg::DATA_W-1:0]        out_read_value,
  input logic                              out_evicted,
  input logic [lct_pkg::DATA_W-1:0]        out_evicted_key
);

  logic in_take;
  logic rd_clean;
  logic evk_clean;

  assign in_take   = in_valid && in_ready;
  assign rd_clean  = out_hit || (out_read_value == '0);
  assign evk_clean = out_evicted || (out_evicted_key == '0);

  // one request at a time: busy right after an accept
  `LCT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_take, !in_ready, "ready after accept")

  // a stalled result word stays offered
  `LCT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result word dropped")

  // a hit never evicts
  `LCT_ASSERT(a_hit_no_evict, clk, rst_n, out_valid |-> !(out_hit && out_evicted), "hit with eviction")

  // fields without meaning read as zero
  `LCT_ASSERT(a_zero_fields, clk, rst_n, out_valid |-> (rd_clean && evk_clean), "stray field bits")

endmodule

bind lfu_cache_table lct_checker u_lct_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_hit         (out_hit),
  .out_read_value  (out_read_value),
  .out_evicted     (out_evicted),
  .out_evicted_key (out_evicted_key)
);

>>> bench/lfu_cache_table_test.sv
module lfu_cache_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = lct_pkg::CAPACITY_DEF;
  localparam int CYCLE_LIMIT = 800000;
  localparam int TAIL_CYCLES = 2 * SLOTS + 8;

  typedef struct {
    logic        op;
    logic [31:0] key;
    logic [31:0] value;
  } request_t;

  typedef struct {
    logic        hit;
    logic [31:0] read_value;
    logic        evicted;
    logic [31:0] evicted_key;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          in_op = 1'b0;
  logic signed [31:0]            in_key = '0;
  logic signed [31:0]            in_value = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          out_hit;
  logic signed [31:0]            out_read_value;
  logic                          out_evicted;
  logic signed [31:0]            out_evicted_key;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [lct_pkg::CAP_REG_W-1:0] cfg_capacity_in_use = '0;

  // table shadow used to predict each reply
  logic        tbl_valid [SLOTS];
  logic [31:0] tbl_key   [SLOTS];
  logic [31:0] tbl_val   [SLOTS];
  logic [31:0] tbl_cnt   [SLOTS];
  int          tbl_rank  [SLOTS];
  logic [4:0]  tbl_cap;

  request_t request_q[$];
  reply_t   pending_replies[$];
  request_t cur_req;

  int  feed_gap = 0;
  int  drain_gap = 0;
  bit  feed_calm = 1'b0;
  bit  drain_calm = 1'b0;
  int  n_errors = 0;
  int  n_results = 0;
  int  n_hits = 0;
  int  n_evictions = 0;
  int  n_cfg = 0;
  int  cycles = 0;

  lfu_cache_table u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_op               (in_op),
    .in_key              (in_key),
    .in_value            (in_value),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_hit             (out_hit),
    .out_read_value      (out_read_value),
    .out_evicted         (out_evicted),
    .out_evicted_key     (out_evicted_key),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_capacity_in_use (cfg_capacity_in_use)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // idle cycles before the next word; now and then flip into a no-idle stretch
  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 13);
  endfunction

  // apply one request to the shadow table and return the reply it causes
  function automatic reply_t predict_access(input request_t rq);
    reply_t r;
    int     live;
    int     found;
    int     slot;
    int     fill;
    int     rk;
    r = '{hit: 1'b0, read_value: '0, evicted: 1'b0, evicted_key: '0};
    live = (int'(tbl_cap) > SLOTS) ? SLOTS : int'(tbl_cap);
    if (live != 0) begin
      found = -1;
      fill = 0;
      for (int i = 0; i < SLOTS; i++) begin
        if (tbl_valid[i]) begin
          fill++;
          if (found < 0 && tbl_key[i] == rq.key) found = i;
        end
      end
      if (found >= 0) begin
        r.hit = 1'b1;
        if (rq.op == lct_pkg::OP_GET) r.read_value = tbl_val[found];
        else tbl_val[found] = rq.value;
        if (tbl_cnt[found] != 32'hFFFF_FFFF) tbl_cnt[found]++;
        // touched entry becomes newest, the ones newer than it age by one
        rk = tbl_rank[found];
        for (int i = 0; i < SLOTS; i++)
          if (tbl_valid[i] && tbl_rank[i] < rk) tbl_rank[i]++;
        tbl_rank[found] = 0;
      end else if (rq.op == lct_pkg::OP_PUT) begin
        slot = -1;
        if (fill >= live) begin
          // victim: lowest count, oldest among equal counts
          for (int i = 0; i < SLOTS; i++) begin
            if (tbl_valid[i] && (slot < 0 || tbl_cnt[i] < tbl_cnt[slot] ||
                (tbl_cnt[i] == tbl_cnt[slot] && tbl_rank[i] > tbl_rank[slot])))
              slot = i;
          end
          if (slot >= 0) begin
            rk = tbl_rank[slot];
            r.evicted = 1'b1;
            r.evicted_key = tbl_key[slot];
            tbl_valid[slot] = 1'b0;
            for (int i = 0; i < SLOTS; i++)
              if (tbl_valid[i] && tbl_rank[i] > rk) tbl_rank[i]--;
          end
        end else begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!tbl_valid[i]) begin
              slot = i;
              break;
            end
          end
        end
        if (slot >= 0) begin
          for (int i = 0; i < SLOTS; i++)
            if (tbl_valid[i]) tbl_rank[i]++;
          tbl_valid[slot] = 1'b1;
          tbl_key[slot] = rq.key;
          tbl_val[slot] = rq.value;
          tbl_cnt[slot] = 32'd1;
          tbl_rank[slot] = 0;
        end
      end
    end
    return r;
  endfunction

  // request driver: presents queued words, predicts each accepted one
  always @(posedge clk) begin : feed
    logic nv;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      nv = in_valid;
      if (in_valid && in_ready) begin
        pending_replies.push_back(predict_access(cur_req));
        nv = 1'b0;
        feed_gap = draw_wait(feed_calm);
      end
      if (!nv) begin
        if (feed_gap > 0) begin
          feed_gap--;
        end else if (request_q.size() > 0) begin
          cur_req = request_q.pop_front();
          nv = 1'b1;
          in_op <= cur_req.op;
          in_key <= cur_req.key;
          in_value <= cur_req.value;
        end
      end
      in_valid <= nv;
    end
  end

  // reply monitor: stalls at random, checks every word against the oldest prediction
  always @(posedge clk) begin : drain
    reply_t w;
    logic   nr;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      nr = out_ready;
      if (out_valid && out_ready) begin
        if (pending_replies.size() == 0) begin
          $error("reply word with no request outstanding");
          n_errors++;
        end else begin
          w = pending_replies.pop_front();
          n_results++;
          if (out_hit) n_hits++;
          if (out_evicted) n_evictions++;
          if (out_hit !== w.hit) begin
            $error("hit: expected %0d, got %0d", w.hit, out_hit);
            n_errors++;
          end
          if (out_read_value !== w.read_value) begin
            $error("read_value: expected %h, got %h", w.read_value, out_read_value);
            n_errors++;
          end
          if (out_evicted !== w.evicted) begin
            $error("evicted: expected %0d, got %0d", w.evicted, out_evicted);
            n_errors++;
          end
          if (out_evicted_key !== w.evicted_key) begin
            $error("evicted_key: expected %h, got %h", w.evicted_key, out_evicted_key);
            n_errors++;
          end
        end
        nr = 1'b0;
        drain_gap = draw_wait(drain_calm);
      end
      if (!nr) begin
        if (drain_gap > 0) drain_gap--;
        else nr = 1'b1;
      end
      out_ready <= nr;
    end
  end

  // run watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding",
               cycles, pending_replies.size());
      $display("lfu_cache_table_test: FAIL");
      $finish;
    end
  end

  task automatic queue_req(input logic op, input logic [31:0] key, input logic [31:0] value);
    request_t rq;
    rq.op = op;
    rq.key = key;
    rq.value = value;
    request_q.push_back(rq);
  endtask

  // settle check at the falling edge, after all rising-edge updates
  task automatic wait_drained();
    do @(negedge clk);
    while (request_q.size() != 0 || in_valid || pending_replies.size() != 0);
  endtask

  task automatic write_capacity(input logic [4:0] cap);
    wait_drained();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_capacity_in_use <= cap;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    tbl_cap = cap;
    n_cfg++;
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // random traffic over a key pool a little larger than the capacity
  task automatic run_random_phase(input logic [4:0] cap, input int count);
    logic [31:0] pool[$];
    int          live;
    int          npool;
    int          sel;
    logic [31:0] key;
    write_capacity(cap);
    live = (int'(cap) > SLOTS) ? SLOTS : int'(cap);
    npool = live + $urandom_range(1, 8);
    for (int i = 0; i < npool; i++)
      pool.push_back(($urandom_range(0, 5) == 0) ? pick_word() : $urandom);
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 19);
      if (sel == 0) key = $urandom;
      else if (sel < 8) key = pool[$urandom_range(0, (npool > 4) ? 3 : npool - 1)];
      else key = pool[$urandom_range(0, npool - 1)];
      queue_req(1'($urandom_range(0, 1)), key, pick_word());
    end
  endtask

  initial begin
    logic [4:0] caps[12];
    for (int i = 0; i < SLOTS; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_key[i] = '0;
      tbl_val[i] = '0;
      tbl_cnt[i] = '0;
      tbl_rank[i] = 0;
    end
    tbl_cap = lct_pkg::CAP_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // empty table, extreme keys and values, put hit replacing a value
    queue_req(lct_pkg::OP_GET, 32'h0000_0000, 32'h7FFF_FFFF);
    queue_req(lct_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_req(lct_pkg::OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_req(lct_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    queue_req(lct_pkg::OP_GET, 32'h8000_0000, 32'hFFFF_FFFF);
    queue_req(lct_pkg::OP_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    queue_req(lct_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    queue_req(lct_pkg::OP_PUT, 32'h0000_0000, 32'h0000_0000);
    queue_req(lct_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_req(lct_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);

    // disabled table: present keys miss, puts change nothing
    write_capacity(5'd0);
    queue_req(lct_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);
    queue_req(lct_pkg::OP_PUT, 32'h0000_1234, 32'h55AA_55AA);
    queue_req(lct_pkg::OP_PUT, 32'h0000_0000, 32'h0000_0001);

    // capacity below the fill, then frequency and age tie-breaks
    write_capacity(5'd2);
    queue_req(lct_pkg::OP_PUT, 32'd5, 32'd50);
    queue_req(lct_pkg::OP_PUT, 32'd6, 32'd60);
    queue_req(lct_pkg::OP_GET, 32'd6, 32'd0);
    queue_req(lct_pkg::OP_PUT, 32'd7, 32'd70);
    queue_req(lct_pkg::OP_GET, 32'd5, 32'd0);
    queue_req(lct_pkg::OP_PUT, 32'd5, 32'd51);
    queue_req(lct_pkg::OP_PUT, 32'd8, 32'd80);

    // capacity beyond the table size saturates
    write_capacity(5'd31);
    queue_req(lct_pkg::OP_GET, 32'd6, 32'd0);
    queue_req(lct_pkg::OP_PUT, 32'd9, 32'd90);

    caps = '{5'd31, 5'd1, 5'd16, 5'd5, 5'd17, 5'd3, 5'd0, 5'd8, 5'd16, 5'd2, 5'd12, 5'd31};
    foreach (caps[i])
      run_random_phase(caps[i], (caps[i] == 5'd0) ? 40 : 180);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("checked %0d replies over %0d capacity writes", n_results, n_cfg);
    $display("  %0d hits, %0d evictions, %0d mismatches", n_hits, n_evictions, n_errors);
    if (n_errors == 0) begin
      $display("lfu_cache_table_test: PASS");
    end else begin
      $display("lfu_cache_table_test: FAIL");
    end
    $finish;
  end

endmodule
